// ----- rtl/core/mlps_pkg.sv -----
// Package for the two-layer perceptron inference block.
// Types, constants and the PLAN sigmoid helper. No dependencies.
package mlps_pkg;
    localparam int MAX_INPUTS_D  = 16;
    localparam int MAX_HIDDEN_D  = 16;
    localparam int MAX_OUTPUTS_D = 16;
    localparam int VALUE_WIDTH_D = 16;
    localparam int CFG_W         = 5;
    localparam int ACC_W         = 48;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic        weight_layer;
        logic [4:0]  weight_row;
        logic [3:0]  weight_col;
        logic signed [15:0] weight_value;
        logic signed [15:0] sample_value;
        logic        sample_last;
    } t_in_item;

    typedef struct packed {
        logic [8:0] output_value;
        logic [3:0] output_index;
        logic       output_last;
    } t_out_item;

    // Item handed from front to back: a weight write or a sample element.
    typedef struct packed {
        logic        is_sample;
        logic        layer;
        logic [4:0]  row;
        logic [3:0]  col;
        logic signed [15:0] value;
        logic        last;
    } t_cmd;

    // PLAN sigmoid on a signed Q8.8 value, result 0..256.
    function automatic logic [8:0] plan_sigmoid(input logic signed [31:0] x);
        logic [31:0] a;
        logic [8:0]  y;
        a = x[31] ? 32'(-x) : 32'(x);
        if (a >= 32'd1280)     y = 9'd256;
        else if (a >= 32'd608) y = 9'(a[10:5]) + 9'd216;
        else if (a >= 32'd256) y = 9'(a[9:3]) + 9'd160;
        else                   y = 9'(a[7:2]) + 9'd128;
        return x[31] ? 9'(9'd256 - y) : y;
    endfunction
endpackage

// ----- rtl/core/mlps_front.sv -----
// Front end: accepts items, classifies them and queues commands for the back end.
// Depends on mlps_pkg.
module mlps_front #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mlps_pkg::t_in_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output mlps_pkg::t_cmd     o_cmd
);
    import mlps_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd           r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;
    logic           push;
    t_cmd           cmd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_start && !o_full;
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        cmd.is_sample = (i_item.req_type == REQ_SAMPLE);
        cmd.layer     = i_item.weight_layer;
        cmd.row       = i_item.weight_row;
        cmd.col       = i_item.weight_col;
        cmd.value     = cmd.is_sample ? i_item.sample_value : i_item.weight_value;
        cmd.last      = i_item.sample_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (push)  r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (i_pop) r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_pop);
        end
    end
endmodule

// ----- rtl/core/mlps_back.sv -----
// Back end: weight stores, sample buffer and a shared multiply-accumulate sequencer.
// Depends on mlps_pkg.
module mlps_back #(
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_HIDDEN  = 16,
    parameter int MAX_OUTPUTS = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mlps_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    input  logic [4:0]          i_ni,
    input  logic [4:0]          i_nh,
    input  logic [4:0]          i_no,
    output logic                o_res_valid,
    output mlps_pkg::t_out_item o_res
);
    import mlps_pkg::*;
    localparam int D1 = (MAX_INPUTS + 1) * MAX_HIDDEN;
    localparam int D2 = (MAX_HIDDEN + 1) * MAX_OUTPUTS;
    localparam int A1 = $clog2(D1);
    localparam int A2 = $clog2(D2);
    localparam int IW = $clog2(MAX_INPUTS + 1);
    localparam int SW = $clog2(MAX_INPUTS);
    localparam int HW = $clog2(MAX_HIDDEN);

    localparam logic [2:0] S_IDLE = 3'd0, S_L1 = 3'd1, S_L1W = 3'd2,
                           S_L2 = 3'd3, S_L2W = 3'd4, S_FIN = 3'd5;

    logic signed [15:0] r_w1 [D1];
    logic signed [15:0] r_w2 [D2];
    logic signed [15:0] r_smp [MAX_INPUTS];
    logic [8:0]         r_hid [MAX_HIDDEN];
    logic [IW-1:0]      r_fill;

    logic [2:0]  r_state;
    logic [4:0]  r_i, r_j;            // source, destination index
    logic [4:0]  r_ni, r_nh, r_no;
    logic        r_mac;               // product pending
    logic        r_bias;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0] r_wrd;
    logic signed [16:0] r_x;
    logic signed [32:0] r_prod;
    logic               r_pv;

    logic idle;
    assign idle  = (r_state == S_IDLE);
    assign o_pop = i_valid && idle;

    // weight writes and sample buffering
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.is_sample) begin
            if (!i_cmd.layer) begin
                if (32'(i_cmd.row) <= MAX_INPUTS && 32'(i_cmd.col) < MAX_HIDDEN)
                    r_w1[A1'(32'(i_cmd.row) * MAX_HIDDEN + 32'(i_cmd.col))] <= i_cmd.value;
            end else begin
                if (32'(i_cmd.row) <= MAX_HIDDEN && 32'(i_cmd.col) < MAX_OUTPUTS)
                    r_w2[A2'(32'(i_cmd.row) * MAX_OUTPUTS + 32'(i_cmd.col))] <= i_cmd.value;
            end
        end
        if (o_pop && i_cmd.is_sample && 32'(r_fill) < MAX_INPUTS)
            r_smp[r_fill[SW-1:0]] <= i_cmd.value;
    end

    // registered weight read for the current (i, j)
    logic [4:0] rd_row;
    assign rd_row = r_bias ? ((r_state == S_L1) ? r_ni : r_nh) : r_i;
    always_ff @(posedge i_clk) begin
        if (r_state == S_L1)
            r_wrd <= r_w1[A1'(32'(rd_row) * MAX_HIDDEN + 32'(r_j))];
        else
            r_wrd <= r_w2[A2'(32'(rd_row) * MAX_OUTPUTS + 32'(r_j))];
    end

    // rounding and saturation of the finished sum
    logic signed [ACC_W-1:0] t_sum, q;
    logic signed [31:0] sat;
    always_comb begin
        t_sum = r_acc + ACC_W'(128);
        q     = t_sum >>> 8;
        if (q > ACC_W'((64'sd1 <<< (VALUE_WIDTH-1)) - 1))
            sat = 32'((64'sd1 <<< (VALUE_WIDTH-1)) - 1);
        else if (q < -ACC_W'(64'sd1 <<< (VALUE_WIDTH-1)))
            sat = 32'(-(64'sd1 <<< (VALUE_WIDTH-1)));
        else
            sat = 32'(q);
    end

    logic [8:0] sig;
    assign sig = plan_sigmoid(sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_mac <= 1'b0; r_pv <= 1'b0;
            o_res_valid <= 1'b0; r_bias <= 1'b0; r_i <= '0; r_j <= '0;
        end else begin
            o_res_valid <= 1'b0;
            // pipeline: weight read -> product -> accumulate
            r_pv <= r_mac;
            if (r_mac) r_prod <= r_x * r_wrd;
            if (r_pv)  r_acc  <= r_acc + ACC_W'(r_prod);
            r_mac <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.is_sample) begin
                        if (32'(r_fill) < MAX_INPUTS) r_fill <= r_fill + 1'b1;
                        if (i_cmd.last) begin
                            r_ni <= (i_ni == 0) ? 5'd1 :
                                (32'(i_ni) > MAX_INPUTS ? 5'(MAX_INPUTS) : i_ni);
                            r_nh <= (i_nh == 0) ? 5'd1 :
                                (32'(i_nh) > MAX_HIDDEN ? 5'(MAX_HIDDEN) : i_nh);
                            r_no <= (i_no == 0) ? 5'd1 :
                                (32'(i_no) > MAX_OUTPUTS ? 5'(MAX_OUTPUTS) : i_no);
                            r_state <= S_L1; r_j <= '0; r_i <= '0; r_bias <= 1'b1;
                            r_acc <= '0;
                        end
                    end
                end
                S_L1, S_L2: begin
                    // weight for (rd_row, j) is read this cycle
                    r_mac <= 1'b1;
                    if (r_bias) r_x <= 17'sd256;
                    else if (r_state == S_L1)
                        r_x <= (32'(r_i) < 32'(r_fill)) ?
                               17'(r_smp[r_i[SW-1:0]]) : '0;
                    else r_x <= 17'(r_hid[r_i[HW-1:0]]);
                    if (r_bias) begin
                        r_bias <= 1'b0; r_i <= '0;
                        if (((r_state == S_L1) ? r_ni : r_nh) == 5'd0)
                            r_state <= r_state + 3'd1;
                    end else if (r_i + 1'b1 == ((r_state == S_L1) ? r_ni : r_nh)) begin
                        r_state <= r_state + 3'd1;
                    end else r_i <= r_i + 1'b1;
                end
                S_L1W, S_L2W: begin
                    // wait for the MAC pipeline to drain
                    if (!r_mac && !r_pv) begin
                        r_acc <= '0; r_bias <= 1'b1; r_i <= '0;
                        if (r_state == S_L1W) begin
                            r_hid[r_j[HW-1:0]] <= sig;
                            if (r_j + 1'b1 == r_nh) begin r_j <= '0; r_state <= S_L2; end
                            else begin r_j <= r_j + 1'b1; r_state <= S_L1; end
                        end else begin
                            o_res_valid <= 1'b1;
                            o_res.output_value <= sig;
                            o_res.output_index <= r_j[3:0];
                            o_res.output_last  <= (r_j + 1'b1 == r_no);
                            if (r_j + 1'b1 == r_no) r_state <= S_FIN;
                            else begin r_j <= r_j + 1'b1; r_state <= S_L2; end
                        end
                    end
                end
                S_FIN: begin r_fill <= '0; r_state <= S_IDLE; end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/mlp_sigmoid_inference.sv -----
// Top level of the two-layer perceptron inference block.
// Instantiates mlps_front and mlps_back; depends on mlps_pkg.
//
// Use:
//  - Input: drive i_item and raise start; the item transfers at an edge where
//    start is high and busy is low. Items are weight writes or sample elements.
//  - Config: i_cfg_we, i_cfg_index, i_cfg_data write input/hidden/output counts;
//    write only while idle. Reset value of each count is 16.
//  - Output: each result shows for one cycle with o_result_valid high; the
//    receiver cannot stall, so results are never held back.
//  - Front queue (4 deep) takes weight writes and samples while the back end
//    computes; busy rises only when the queue is full.
//  - Weight writes and non-last samples are taken by the back end while it is idle.
//  - A last sample starts layer 1, then layer 2, on the single shared
//    multiply-accumulate; the back end takes no new item until both layers
//    are done and the last output is out.
//  - Outputs come in index order, the last flagged by output_last.
//  - Reset (synchronous, active low) empties the queue and the sample buffer;
//    the weight stores are not cleared and must be written before use.
module mlp_sigmoid_inference #(
    parameter int MAX_INPUTS  = mlps_pkg::MAX_INPUTS_D,
    parameter int MAX_HIDDEN  = mlps_pkg::MAX_HIDDEN_D,
    parameter int MAX_OUTPUTS = mlps_pkg::MAX_OUTPUTS_D,
    parameter int VALUE_WIDTH = mlps_pkg::VALUE_WIDTH_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mlps_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [4:0]          i_cfg_data,
    output logic                o_result_valid,
    output mlps_pkg::t_out_item o_result
);
    import mlps_pkg::*;

    logic [4:0] r_ni, r_nh, r_no;
    logic       q_valid, pop;
    t_cmd       q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ni <= 5'd16; r_nh <= 5'd16; r_no <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INPUT_COUNT:  r_ni <= i_cfg_data;
                REG_HIDDEN_COUNT: r_nh <= i_cfg_data;
                REG_OUTPUT_COUNT: r_no <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlps_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_item,
        .o_full(busy), .i_pop(pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    mlps_back #(
        .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN),
        .MAX_OUTPUTS(MAX_OUTPUTS), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .i_ni(r_ni), .i_nh(r_nh), .i_no(r_no),
        .o_res_valid(o_result_valid), .o_res(o_result)
    );
endmodule

// ----- rtl/core/mlps_checker.sv -----
// Port-level checks for the perceptron block, bound to the top level.
// Depends on mlps_pkg.
module mlps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                busy,
    input logic                o_result_valid,
    input mlps_pkg::t_out_item o_result
);
    import mlps_pkg::*;

    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_result.output_value <= 9'd256)
        else $error("output above 1.0");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && $past(o_result_valid) && !$past(o_result.output_last)
        |-> o_result.output_index != $past(o_result.output_index))
        else $error("index repeated");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid && !busy)
        else $error("activity after reset");
endmodule

bind mlp_sigmoid_inference mlps_checker u_chk (
    .i_clk, .i_rst_n, .busy, .o_result_valid, .o_result
);
